[rtl/ic8259_pkg.sv]
// Package for the 8259-subset interrupt controller: operation codes, command bits and helpers.
package ic8259_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_PORT_READ  = 2'd0,
        OP_PORT_WRITE = 2'd1,
        OP_RAISE_IRQ  = 2'd2,
        OP_INT_ACK    = 2'd3
    } op_t;

    // Port select codes
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Command port bit positions and masks
    localparam int unsigned CMD_ICW1_BIT   = 4;
    localparam int unsigned CMD_EOI_BIT    = 5;
    localparam int unsigned CMD_RIS_BIT    = 1;
    localparam logic [7:0]  OCW3_SEL_MASK  = 8'h98;
    localparam logic [7:0]  OCW3_SEL_VALUE = 8'h08;

    // ICW1 bit that means "single mode", which skips ICW3
    localparam int unsigned ICW1_SNGL_BIT = 1;

    // Init sequence steps
    localparam logic [2:0] STEP_ICW1      = 3'd1;
    localparam logic [2:0] STEP_ICW2      = 3'd2;
    localparam logic [2:0] STEP_ICW3      = 3'd3;
    localparam logic [2:0] STEP_ICW4      = 3'd4;
    localparam logic [2:0] STEP_DONE      = 3'd5;

    // Vector that marks a keyboard event
    localparam logic [7:0] KEY_VECTOR = 8'd9;

    // Packed widths of the stream payloads
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 24;

    // Lowest-set-bit search result
    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } lsb_t;

    // Finds the lowest set bit of a byte.
    function automatic lsb_t lowest_bit(input logic [7:0] v);
        lsb_t r;
        r.found = 1'b0;
        r.idx   = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

[rtl/interrupt_controller_8259_subset_unit.sv]
// Top level of the 8259-subset interrupt controller: input register, update logic, result register.
//
//  Channel  | Direction | Payload (low bit first)
//  ---------+-----------+---------------------------------------------------------------
//  s_       | in        | op[1:0], port_sel, write_data[7:0], irq_line[2:0], makeup_pending
//  m_       | out       | read_data[7:0], vector[7:0], pending, clear_makeup, key_handled
//
// An item is held in the input register and is then loaded into the result register;
// one item is taken every cycle while m_tready does not hold the result register.
// The controller registers are updated at the same edge the result is loaded, so the
// following item always sees them. Reset is synchronous and active low. When the result
// register is held by m_tready low, the input register holds too and s_tready drops
// once it is full.
module interrupt_controller_8259_subset_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // op[1:0], port_sel[2], write_data[10:3], irq_line[13:11], makeup_pending[14]
    input  logic [ic8259_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_data[7:0], vector[15:8], pending[16], clear_makeup[17], key_handled[18]
    output logic [ic8259_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Input stage
    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    logic       in_port_reg;
    logic [7:0] in_data_reg;
    logic [2:0] in_line_reg;
    logic       in_owed_reg;

    // Controller state
    logic [7:0] irr_reg, irr_next;
    logic [7:0] isr_reg, isr_next;
    logic [7:0] imr_reg, imr_next;
    logic [2:0] step_reg, step_next;
    logic [7:0] icw1_reg, icw1_next;
    logic [7:0] icw2_reg, icw2_next;
    logic       ris_reg, ris_next;

    // Result stage
    logic       out_valid_reg;
    logic [7:0] rd_reg, rd_next;
    logic [7:0] vec_reg, vec_next;
    logic       pend_reg, pend_next;
    logic       clr_reg, clr_next;
    logic       key_reg, key_next;

    logic                  advance;
    logic [2:0]            step_eff;
    logic [7:0]            ack_req;
    ic8259_pkg::lsb_t      isr_low;
    ic8259_pkg::lsb_t      ack_low;

    // The result register frees up when it is empty or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tdata[1:0];
            in_port_reg <= s_tdata[2];
            in_data_reg <= s_tdata[10:3];
            in_line_reg <= s_tdata[13:11];
            in_owed_reg <= s_tdata[14];
        end
    end

    // Priority searches over in-service and unmasked requests.
    assign ack_req = irr_reg & ~imr_reg;
    assign isr_low = ic8259_pkg::lowest_bit(isr_reg);
    assign ack_low = ic8259_pkg::lowest_bit(ack_req);

    // In single mode the ICW3 step is skipped.
    assign step_eff = (step_reg == ic8259_pkg::STEP_ICW3 && icw1_reg[ic8259_pkg::ICW1_SNGL_BIT])
                      ? ic8259_pkg::STEP_ICW4 : step_reg;

    // Item update logic
    always_comb begin
        irr_next  = irr_reg;
        isr_next  = isr_reg;
        imr_next  = imr_reg;
        step_next = step_reg;
        icw1_next = icw1_reg;
        icw2_next = icw2_reg;
        ris_next  = ris_reg;
        rd_next   = 8'd0;
        vec_next  = 8'd0;
        clr_next  = 1'b0;
        key_next  = 1'b0;

        case (ic8259_pkg::op_t'(in_op_reg))
            ic8259_pkg::OP_PORT_READ: begin
                if (in_port_reg == ic8259_pkg::PORT_CMD) begin
                    rd_next = ris_reg ? isr_reg : irr_reg;
                end else begin
                    rd_next = imr_reg;
                end
            end
            ic8259_pkg::OP_PORT_WRITE: begin
                if (in_port_reg == ic8259_pkg::PORT_CMD) begin
                    if (in_data_reg[ic8259_pkg::CMD_ICW1_BIT]) begin
                        // ICW1 starts the init sequence and clears the mask.
                        imr_next  = 8'd0;
                        icw1_next = in_data_reg;
                        step_next = ic8259_pkg::STEP_ICW2;
                    end else begin
                        // OCW3 read-ISR select is sticky.
                        if ((in_data_reg & ic8259_pkg::OCW3_SEL_MASK) ==
                                ic8259_pkg::OCW3_SEL_VALUE &&
                                in_data_reg[ic8259_pkg::CMD_RIS_BIT]) begin
                            ris_next = 1'b1;
                        end
                        // Non-specific EOI clears the highest-priority in-service bit.
                        if (in_data_reg[ic8259_pkg::CMD_EOI_BIT] && isr_low.found) begin
                            isr_next[isr_low.idx] = 1'b0;
                            if (isr_low.idx == 3'd0 && in_owed_reg) begin
                                irr_next[0] = 1'b1;
                                clr_next    = 1'b1;
                            end
                        end
                    end
                end else begin
                    // Data port: init words until the sequence ends, then the mask.
                    if (step_eff < ic8259_pkg::STEP_DONE) begin
                        if (step_eff == ic8259_pkg::STEP_ICW1) begin
                            icw1_next = in_data_reg;
                        end
                        if (step_eff == ic8259_pkg::STEP_ICW2) begin
                            icw2_next = in_data_reg;
                        end
                        step_next = step_eff + 3'd1;
                    end else begin
                        step_next = step_eff;
                        imr_next  = in_data_reg;
                    end
                end
            end
            ic8259_pkg::OP_RAISE_IRQ: begin
                irr_next[in_line_reg] = 1'b1;
            end
            ic8259_pkg::OP_INT_ACK: begin
                if (ack_low.found) begin
                    irr_next[ack_low.idx] = 1'b0;
                    isr_next[ack_low.idx] = 1'b1;
                    vec_next = icw2_reg + {5'd0, ack_low.idx};
                    key_next = (vec_next == ic8259_pkg::KEY_VECTOR);
                end
            end
            default: begin
                rd_next = 8'd0;
            end
        endcase

        pend_next = |(irr_next & ~imr_next);
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            irr_reg       <= 8'd0;
            isr_reg       <= 8'd0;
            imr_reg       <= 8'd0;
            step_reg      <= 3'd0;
            icw1_reg      <= 8'd0;
            icw2_reg      <= 8'd0;
            ris_reg       <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                irr_reg  <= irr_next;
                isr_reg  <= isr_next;
                imr_reg  <= imr_next;
                step_reg <= step_next;
                icw1_reg <= icw1_next;
                icw2_reg <= icw2_next;
                ris_reg  <= ris_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            rd_reg   <= rd_next;
            vec_reg  <= vec_next;
            pend_reg <= pend_next;
            clr_reg  <= clr_next;
            key_reg  <= key_next;
        end
    end

    // Result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, key_reg, clr_reg, pend_reg, vec_reg, rd_reg};

endmodule
